// ----- design/fva_pkg.sv -----
// fva_pkg: shared types, constants and small functions of the fm voice allocator
// register table, factory patch table, operator offsets and total level scaling
// no dependencies
package fva_pkg;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_ALLOC,
    ST_NRD,
    ST_NWR,
    ST_OFF,
    ST_LRD,
    ST_LWR
  } state_e;

  typedef enum logic [2:0] {
    CMD_NOTE_ON     = 3'd0,
    CMD_NOTE_OFF    = 3'd1,
    CMD_ALL_OFF     = 3'd2,
    CMD_PROGRAM     = 3'd3,
    CMD_VOLUME      = 3'd4,
    CMD_WHEEL       = 3'd5,
    CMD_PATCH_WRITE = 3'd6,
    CMD_TABLE_WRITE = 3'd7
  } cmd_e;

  localparam logic CFG_ENABLED = 1'b0;
  localparam logic CFG_SOCKET  = 1'b1;

  localparam int NOTES       = 128;
  localparam int NOTE_W      = 7;
  localparam int PITCH_W     = 13;
  localparam int AGE_W       = 32;
  localparam int PATCH_BYTES = 11;

  localparam logic [3:0] BYTE_KSL_TL  = 4'd2;
  localparam logic [3:0] BYTE_FB      = 4'd10;
  localparam logic [3:0] STEP_FB      = 4'd10;
  localparam logic [3:0] STEP_FNUM    = 4'd11;
  localparam logic [3:0] STEP_KEY     = 4'd12;
  localparam logic [2:0] J_LAST       = 3'd4;
  localparam logic [2:0] J_TL         = 3'd1;

  localparam logic [7:0] REG_MULT     = 8'h20;
  localparam logic [7:0] REG_KSL_TL   = 8'h40;
  localparam logic [7:0] REG_AR_DR    = 8'h60;
  localparam logic [7:0] REG_SL_RR    = 8'h80;
  localparam logic [7:0] REG_WAVE     = 8'hE0;
  localparam logic [7:0] REG_FEEDBACK = 8'hC0;
  localparam logic [7:0] REG_FNUM     = 8'hA0;
  localparam logic [7:0] REG_KEY      = 8'hB0;
  localparam logic [7:0] KEY_ON       = 8'h20;
  localparam logic [6:0] LEVEL_MAX    = 7'd127;

  localparam logic [7:0] FACTORY [6][11] = '{
    '{8'h21, 8'h21, 8'h1C, 8'h00, 8'hF0, 8'hF0, 8'h0F, 8'h0F, 8'h00, 8'h00, 8'h00},
    '{8'h31, 8'h21, 8'h18, 8'h00, 8'hF2, 8'hD2, 8'h5F, 8'h3F, 8'h01, 8'h00, 8'h04},
    '{8'h11, 8'h21, 8'h10, 8'h00, 8'hF3, 8'hC4, 8'h8F, 8'h4F, 8'h00, 8'h00, 8'h02},
    '{8'h21, 8'h21, 8'h00, 8'h00, 8'hA3, 8'hF0, 8'h0F, 8'h0F, 8'h00, 8'h00, 8'h06},
    '{8'h71, 8'h21, 8'h00, 8'h00, 8'hF6, 8'hF3, 8'h1F, 8'h2F, 8'h00, 8'h00, 8'h02},
    '{8'h21, 8'h21, 8'h20, 8'h08, 8'h72, 8'h72, 8'h0F, 8'h0F, 8'h00, 8'h00, 8'h00}
  };

  function automatic logic [7:0] factory_byte(logic [7:0] p, logic [3:0] b);
    logic [7:0] r;
    r = 8'h00;
    if (p < 8'd6 && b < 4'(PATCH_BYTES)) r = FACTORY[p[2:0]][b];
    return r;
  endfunction

  function automatic logic [7:0] op_reg_base(logic [2:0] j);
    logic [7:0] r;
    case (j)
      3'd0: r = REG_MULT;
      3'd1: r = REG_KSL_TL;
      3'd2: r = REG_AR_DR;
      3'd3: r = REG_SL_RR;
      default: r = REG_WAVE;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] op_offset(logic [3:0] s, logic op);
    logic [7:0] r;
    case (s)
      4'd0: r = 8'h00;
      4'd1: r = 8'h01;
      4'd2: r = 8'h02;
      4'd3: r = 8'h08;
      4'd4: r = 8'h09;
      4'd5: r = 8'h0A;
      4'd6: r = 8'h10;
      4'd7: r = 8'h11;
      default: r = 8'h12;
    endcase
    return op ? r + 8'h03 : r;
  endfunction

  // x*48/127 and x*24/127 via reciprocal 8257/2^20, exact for x up to 127
  function automatic logic [7:0] scale_tl(logic [7:0] ksl_tl, logic [6:0] vol,
                                          logic [6:0] boost);
    logic [25:0] pa;
    logic [24:0] pb;
    logic signed [8:0] tl;
    logic [5:0] t;
    pa = 26'(LEVEL_MAX - vol) * 26'd396336;
    pb = 25'(boost) * 25'd198168;
    tl = $signed({3'b000, ksl_tl[5:0]}) + $signed({3'b000, pa[25:20]})
         - $signed({4'b0000, pb[24:20]});
    if (tl < 0) t = 6'd0;
    else if (tl > 9'sd63) t = 6'd63;
    else t = tl[5:0];
    return {ksl_tl[7:6], t};
  endfunction

endpackage

// ----- design/fm_voice_allocator_register_writer_unit.sv -----
// fm voice allocator and register writer, top level
// uses fva_pkg and two fva_ram instances (patch store, note table)
//
// channel | handshake              | payload
// cfg     | cfg_we_i               | cfg_index_i, cfg_data_i
// in      | in_valid_i / in_stall_o| cmd, channel, note, value, patch, table fields
// out     | out_valid_o/out_stall_i| bus_base, reg_index, reg_data, last
//
// after reset a sweep loads the patch store byte by byte; no transfer meanwhile
// one command at a time: note on issues 13 writes after the oldest-voice scan and
// the allocation, with a patch ram read before each write
// key off writes without a ram read, level rewrite reads the patch ram before each write
// output stall holds the sequencer at the write in progress
module fm_voice_allocator_register_writer_unit import fva_pkg::*; #(
  parameter int VOICES   = 9,
  parameter int CHANNELS = 16,
  parameter int PATCHES  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [2:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [3:0]  channel_i,
  input  logic [6:0]  note_i,
  input  logic [7:0]  value_i,
  input  logic [4:0]  patch_slot_i,
  input  logic [3:0]  patch_byte_i,
  input  logic [2:0]  table_block_i,
  input  logic [9:0]  table_fnum_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  bus_base_o,
  output logic [7:0]  reg_index_o,
  output logic [7:0]  reg_data_o,
  output logic        last_o
);

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW = (PATCHES > 1) ? $clog2(PATCHES) : 1;
  localparam int PD = PATCHES * PATCH_BYTES;
  localparam int AW = $clog2(PD);

  state_e state_q, state_d;

  logic       enabled_q;
  logic [2:0] socket_q;

  logic [2:0] cmd_q;
  logic [3:0] ch_q;
  logic [6:0] note_q;
  logic [7:0] value_q;
  logic [4:0] pslot_q;
  logic [3:0] pbyte_q;
  logic [2:0] tblock_q;
  logic [9:0] tfnum_q;

  logic                busy_q  [VOICES];
  logic [3:0]          vchan_q [VOICES];
  logic [NOTE_W-1:0]   vnote_q [VOICES];
  logic [PW-1:0]       vpatch_q[VOICES];
  logic [PITCH_W-1:0]  vpitch_q[VOICES];
  logic [AGE_W-1:0]    vage_q  [VOICES];
  logic [AGE_W-1:0]    age_cnt_q;

  logic [PW-1:0] ch_patch_q[CHANNELS];
  logic [6:0]    ch_vol_q  [CHANNELS];
  logic [6:0]    ch_wheel_q[CHANNELS];

  logic [VW-1:0]      cnt_q, best_q, slot_q;
  logic [AGE_W-1:0]   best_age_q;
  logic [VOICES-1:0]  mask_q;
  logic [3:0]         k_q, byte_q;
  logic [2:0]         j_q;
  logic               op_q;
  logic [PW-1:0]      np_q;
  logic [PITCH_W-1:0] pitch_q;
  logic [PW-1:0]      clr_p_q;
  logic [3:0]         clr_b_q;

  logic       out_valid_q, last_q;
  logic [7:0] base_q, idx_q, data_q;

  logic [VOICES-1:0] hit_v, free_v, match_v, busy_v;
  logic [VW-1:0]     lsel, alloc_sel;
  logic              ch_ok, single, out_free, emit;
  logic [CW-1:0]     chi;
  logic [7:0]        em_idx, em_data, bus_base;
  logic              em_last;
  logic [6:0]        sat;

  logic              pram_we;
  logic [AW-1:0]     pram_waddr, pram_raddr;
  logic [7:0]        pram_wdata, pram_rdata;
  logic              nram_we;
  logic [PITCH_W-1:0] nram_rdata;
  logic [PW-1:0]     rpatch;

  function automatic logic [VW-1:0] low_idx(logic [VOICES-1:0] v);
    logic [VW-1:0] r;
    logic          f;
    r = '0;
    f = 1'b0;
    for (int i = 0; i < VOICES; i++) begin
      if (v[i] && !f) begin
        r = VW'(i);
        f = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] paddr(logic [PW-1:0] p, logic [3:0] b);
    logic [AW-1:0] e;
    e = AW'(p);
    return (e << 3) + (e << 1) + e + AW'(b);
  endfunction

  always_comb begin
    for (int i = 0; i < VOICES; i++) begin
      busy_v[i]  = busy_q[i];
      free_v[i]  = !busy_q[i];
      match_v[i] = busy_q[i] && vchan_q[i] == ch_q;
      hit_v[i]   = match_v[i] && vnote_q[i] == note_q;
    end
  end

  assign ch_ok     = {1'b0, ch_q} < 5'(CHANNELS);
  assign chi       = CW'(ch_q);
  assign lsel      = low_idx(mask_q);
  assign alloc_sel = (|hit_v) ? low_idx(hit_v) : ((|free_v) ? low_idx(free_v) : best_q);
  assign single    = (mask_q & (mask_q - VOICES'(1))) == '0;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign sat       = value_q[7] ? LEVEL_MAX : value_q[6:0];
  assign bus_base  = {(socket_q == 3'd0) ? 3'd0 : socket_q - 3'd1, 5'b00000};
  assign in_stall_o = (state_q != ST_IDLE);

  // patch store port
  assign rpatch     = (cmd_q == CMD_NOTE_ON) ? np_q : vpatch_q[lsel];
  assign pram_raddr = paddr(rpatch, byte_q);
  always_comb begin
    pram_we    = 1'b0;
    pram_waddr = paddr(PW'(pslot_q), pbyte_q);
    pram_wdata = value_q;
    if (state_q == ST_CLEAR) begin
      pram_we    = 1'b1;
      pram_waddr = paddr(clr_p_q, clr_b_q);
      pram_wdata = factory_byte(8'(clr_p_q), clr_b_q);
    end else if (state_q == ST_DISPATCH && cmd_q == CMD_PATCH_WRITE &&
                 {4'b0000, pslot_q} < 9'(PATCHES) && pbyte_q < 4'(PATCH_BYTES)) begin
      pram_we = 1'b1;
    end
  end

  assign nram_we = state_q == ST_DISPATCH && cmd_q == CMD_TABLE_WRITE;

  fva_ram #(.W(8), .D(PD)) u_patch_ram (
    .clk_i   (clk_i),
    .we_i    (pram_we),
    .waddr_i (pram_waddr),
    .wdata_i (pram_wdata),
    .raddr_i (pram_raddr),
    .rdata_o (pram_rdata)
  );

  fva_ram #(.W(PITCH_W), .D(NOTES)) u_note_ram (
    .clk_i   (clk_i),
    .we_i    (nram_we),
    .waddr_i (note_q),
    .wdata_i ({tblock_q, tfnum_q}),
    .raddr_i (note_q),
    .rdata_o (nram_rdata)
  );

  // write being produced
  always_comb begin
    em_idx  = '0;
    em_data = '0;
    em_last = 1'b0;
    case (state_q)
      ST_NWR: begin
        if (k_q < STEP_FB) begin
          em_idx  = op_reg_base(j_q) + op_offset(4'(slot_q), op_q);
          em_data = (j_q == J_TL) ?
                    scale_tl(pram_rdata, ch_vol_q[chi], op_q ? 7'd0 : ch_wheel_q[chi]) :
                    pram_rdata;
        end else if (k_q == STEP_FB) begin
          em_idx  = REG_FEEDBACK + 8'(slot_q);
          em_data = pram_rdata;
        end else if (k_q == STEP_FNUM) begin
          em_idx  = REG_FNUM + 8'(slot_q);
          em_data = pitch_q[7:0];
        end else begin
          em_idx  = REG_KEY + 8'(slot_q);
          em_data = {3'b000, pitch_q[12:8]} | KEY_ON;
          em_last = 1'b1;
        end
      end
      ST_OFF: begin
        em_idx  = REG_KEY + 8'(lsel);
        em_data = {3'b000, vpitch_q[lsel][12:8]};
        em_last = single;
      end
      ST_LWR: begin
        em_idx  = REG_KSL_TL + op_offset(4'(lsel), op_q);
        em_data = scale_tl(pram_rdata, ch_vol_q[chi], op_q ? 7'd0 : ch_wheel_q[chi]);
        em_last = op_q && single;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    emit    = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_p_q == PW'(PATCHES - 1) && clr_b_q == 4'(PATCH_BYTES - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        state_d = ST_IDLE;
        case (cmd_e'(cmd_q))
          CMD_NOTE_ON: if (enabled_q && ch_ok) state_d = ST_SCAN;
          CMD_NOTE_OFF: if (enabled_q && ch_ok && |hit_v) state_d = ST_OFF;
          CMD_ALL_OFF: if (enabled_q && ch_ok && |busy_v) state_d = ST_OFF;
          CMD_VOLUME, CMD_WHEEL: if (enabled_q && ch_ok && |match_v) state_d = ST_LRD;
          default: ;
        endcase
      end
      ST_SCAN: begin
        if (cnt_q == VW'(VOICES - 1)) state_d = ST_ALLOC;
      end
      ST_ALLOC: state_d = ST_NRD;
      ST_NRD:   state_d = ST_NWR;
      ST_NWR: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = (k_q == STEP_KEY) ? ST_IDLE : ST_NRD;
        end
      end
      ST_OFF: begin
        if (out_free) begin
          emit = 1'b1;
          if (single) state_d = ST_IDLE;
        end
      end
      ST_LRD: state_d = ST_LWR;
      ST_LWR: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = (op_q && single) ? ST_IDLE : ST_LRD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      socket_q  <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_ENABLED) enabled_q <= cfg_data_i[0];
      else socket_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      cmd_q    <= cmd_i;
      ch_q     <= channel_i;
      note_q   <= note_i;
      value_q  <= value_i;
      pslot_q  <= patch_slot_i;
      pbyte_q  <= patch_byte_i;
      tblock_q <= table_block_i;
      tfnum_q  <= table_fnum_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VOICES; i++) begin
        busy_q[i]   <= 1'b0;
        vchan_q[i]  <= '0;
        vnote_q[i]  <= '0;
        vpatch_q[i] <= '0;
        vpitch_q[i] <= '0;
        vage_q[i]   <= '0;
      end
      for (int c = 0; c < CHANNELS; c++) begin
        ch_patch_q[c] <= '0;
        ch_vol_q[c]   <= LEVEL_MAX;
        ch_wheel_q[c] <= '0;
      end
      age_cnt_q  <= '0;
      cnt_q      <= '0;
      best_q     <= '0;
      best_age_q <= '0;
      slot_q     <= '0;
      mask_q     <= '0;
      k_q        <= '0;
      j_q        <= '0;
      op_q       <= 1'b0;
      byte_q     <= '0;
      np_q       <= '0;
      pitch_q    <= '0;
      clr_p_q    <= '0;
      clr_b_q    <= '0;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          if (clr_b_q == 4'(PATCH_BYTES - 1)) begin
            clr_b_q <= '0;
            clr_p_q <= clr_p_q + PW'(1);
          end else begin
            clr_b_q <= clr_b_q + 4'd1;
          end
        end
        ST_DISPATCH: begin
          cnt_q  <= '0;
          op_q   <= 1'b0;
          byte_q <= BYTE_KSL_TL;
          case (cmd_e'(cmd_q))
            CMD_PROGRAM: begin
              if (ch_ok && {1'b0, value_q} < 9'(PATCHES)) ch_patch_q[chi] <= PW'(value_q);
            end
            CMD_VOLUME: begin
              if (ch_ok) ch_vol_q[chi] <= sat;
              mask_q <= match_v;
            end
            CMD_WHEEL: begin
              if (ch_ok) ch_wheel_q[chi] <= sat;
              mask_q <= match_v;
            end
            CMD_NOTE_OFF: mask_q <= hit_v & (~hit_v + VOICES'(1));
            CMD_ALL_OFF:  mask_q <= busy_v;
            default: ;
          endcase
        end
        ST_SCAN: begin
          if (cnt_q == '0 || vage_q[cnt_q] < best_age_q) begin
            best_q     <= cnt_q;
            best_age_q <= vage_q[cnt_q];
          end
          cnt_q <= cnt_q + VW'(1);
        end
        ST_ALLOC: begin
          slot_q              <= alloc_sel;
          busy_q[alloc_sel]   <= 1'b1;
          vchan_q[alloc_sel]  <= ch_q;
          vnote_q[alloc_sel]  <= note_q;
          vpatch_q[alloc_sel] <= ch_patch_q[chi];
          vpitch_q[alloc_sel] <= nram_rdata;
          vage_q[alloc_sel]   <= age_cnt_q + AGE_W'(1);
          age_cnt_q           <= age_cnt_q + AGE_W'(1);
          np_q                <= ch_patch_q[chi];
          pitch_q             <= nram_rdata;
          k_q                 <= '0;
          j_q                 <= '0;
          op_q                <= 1'b0;
          byte_q              <= '0;
        end
        ST_NWR: begin
          if (emit) begin
            k_q <= k_q + 4'd1;
            if (k_q + 4'd1 >= STEP_FB) begin
              byte_q <= BYTE_FB;
            end else if (j_q == J_LAST) begin
              j_q    <= '0;
              op_q   <= 1'b1;
              byte_q <= 4'd1;
            end else begin
              j_q    <= j_q + 3'd1;
              byte_q <= {j_q + 3'd1, op_q};
            end
          end
        end
        ST_OFF: begin
          if (emit) begin
            busy_q[lsel] <= 1'b0;
            mask_q[lsel] <= 1'b0;
          end
        end
        ST_LWR: begin
          if (emit) begin
            if (op_q) begin
              op_q         <= 1'b0;
              byte_q       <= BYTE_KSL_TL;
              mask_q[lsel] <= 1'b0;
            end else begin
              op_q   <= 1'b1;
              byte_q <= BYTE_KSL_TL + 4'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      base_q <= bus_base;
      idx_q  <= em_idx;
      data_q <= em_data;
      last_q <= em_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign bus_base_o  = base_q;
  assign reg_index_o = idx_q;
  assign reg_data_o  = data_q;
  assign last_o      = last_q;

endmodule

// ----- design/fva_ram.sv -----
// fva_ram: generic single write port, single read port ram with registered read
// no dependencies
module fva_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end

endmodule
